### hdl/saturating_scalar_type_converter_macros.svh
// assertion macros for the saturating scalar type converter
// expects clk_i and rst_ni in the scope that uses them
`ifndef SATURATING_SCALAR_TYPE_CONVERTER_MACROS_SVH
`define SATURATING_SCALAR_TYPE_CONVERTER_MACROS_SVH

// property checked at every clock edge outside reset
`define SSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ssc_pkg.sv
// types and constants for the saturating scalar type converter
// no dependencies
`timescale 1ns / 1ps

package ssc_pkg;

  // type codes shared by source_type and mode
  typedef enum logic [3:0] {
    TY_U8    = 4'd0,
    TY_U16   = 4'd1,
    TY_U32   = 4'd2,
    TY_U64   = 4'd3,
    TY_S8    = 4'd4,
    TY_S16   = 4'd5,
    TY_S32   = 4'd6,
    TY_S64   = 4'd7,
    TY_BOOL  = 4'd8,
    TY_SCHAR = 4'd9,
    TY_F32   = 4'd10,
    TY_F64   = 4'd11
  } type_e;

  // value class after decode
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FIN  = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_e;

  // input transfer
  typedef struct packed {
    logic [3:0]  source_type;
    logic [63:0] raw_value;
    logic [3:0]  mode;
  } in_t;

  // output transfer
  typedef struct packed {
    logic [63:0] result_value;
    logic        error_code;
  } out_t;

  // biased exponent plus 63 for the normalized 64-bit significand
  localparam logic [12:0] F32_EXP_OFS = 13'd190;
  localparam logic [12:0] F64_EXP_OFS = 13'd1086;
  // right shift that leaves the hidden bit at bit m
  localparam logic [12:0] F32_SHIFT = 13'd40;
  localparam logic [12:0] F64_SHIFT = 13'd11;

endpackage

### hdl/saturating_scalar_type_converter.sv
// Saturating scalar type converter.
//
// Input channel: in_valid_i / in_stall_o carry in_data_i (source type, raw
// 64-bit word, destination mode). Output channel: out_valid_o / out_stall_i
// carry out_data_o (zero-extended result and error flag). A transfer happens
// on a rising edge with valid high and stall low.
// Stages: input register, decode and leading-zero count, shift, round and
// saturate into the output register. Throughput: one item per cycle while
// out_stall_i is low; the limit is the single pass through each of these
// stages.
// Every stage holds a valid bit and fills its bubbles, so a new item is
// taken while a finished result waits. in_stall_o rises only when all four
// stages are full and the receiver stalls; the offered result then holds.
// Reset clears all valid bits; the block is stateless otherwise.
// Depends on ssc_pkg and saturating_scalar_type_converter_macros.svh.
`timescale 1ns / 1ps

`include "saturating_scalar_type_converter_macros.svh"

module saturating_scalar_type_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ssc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ssc_pkg::out_t out_data_o
);
  import ssc_pkg::*;

  typedef struct packed {
    cls_e               cls;
    logic               neg;
    logic [63:0]        sig;
    logic signed [12:0] exp;
    logic [51:0]        payload;
    logic [5:0]         lz;
    logic [3:0]         mode;
  } dec_t;

  typedef struct packed {
    cls_e               cls;
    logic               neg;
    logic [51:0]        payload;
    logic [3:0]         mode;
    logic [63:0]        mag;
    logic [52:0]        kept;
    logic               rnd;
    logic               sticky;
    logic               tiny;
    logic signed [12:0] biased;
  } shf_t;

  // leading zero count by halving search
  function automatic logic [5:0] lzc64(input logic [63:0] x);
    logic [63:0] v;
    logic [5:0]  n;
    v = x;
    n = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((v >> (64 - (1 << k))) == 64'd0) begin
        n[k] = 1'b1;
        v = v << (1 << k);
      end
    end
    return n;
  endfunction

  logic v0_q, v1_q, v2_q, vo_q;
  logic ld0, ld1, ld2, free_o;
  in_t  in_q;
  dec_t s1_q, s1_d;
  shf_t s2_q, s2_d;
  out_t out_q, out_d;

  // stage handshake, each stage loads when empty or draining
  assign free_o     = !vo_q || !out_stall_i;
  assign ld2        = !v2_q || free_o;
  assign ld1        = !v1_q || ld2;
  assign ld0        = !v0_q || ld1;
  assign in_stall_o = !ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld0)    v0_q <= in_valid_i;
      if (ld1)    v1_q <= v0_q;
      if (ld2)    v2_q <= v1_q;
      if (free_o) vo_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld0)    in_q  <= in_data_i;
    if (ld1)    s1_q  <= s1_d;
    if (ld2)    s2_q  <= s2_d;
    if (free_o) out_q <= out_d;
  end

  // decode source into class, sign, magnitude and exponent
  always_comb begin
    logic [63:0] r;
    logic [7:0]  e8;
    logic [10:0] e11;
    r = in_q.raw_value;
    e8 = r[30:23];
    e11 = r[62:52];
    s1_d.cls = CLS_ZERO;
    s1_d.neg = 1'b0;
    s1_d.sig = '0;
    s1_d.exp = '0;
    s1_d.payload = '0;
    s1_d.mode = in_q.mode;
    case (in_q.source_type)
      TY_U8:  s1_d.sig = {56'd0, r[7:0]};
      TY_U16: s1_d.sig = {48'd0, r[15:0]};
      TY_U32: s1_d.sig = {32'd0, r[31:0]};
      TY_U64: s1_d.sig = r;
      TY_S8, TY_SCHAR: begin
        s1_d.neg = r[7];
        s1_d.sig = r[7] ? 64'd0 - {{56{1'b1}}, r[7:0]} : {56'd0, r[7:0]};
      end
      TY_S16: begin
        s1_d.neg = r[15];
        s1_d.sig = r[15] ? 64'd0 - {{48{1'b1}}, r[15:0]} : {48'd0, r[15:0]};
      end
      TY_S32: begin
        s1_d.neg = r[31];
        s1_d.sig = r[31] ? 64'd0 - {{32{1'b1}}, r[31:0]} : {32'd0, r[31:0]};
      end
      TY_S64: begin
        s1_d.neg = r[63];
        s1_d.sig = r[63] ? 64'd0 - r : r;
      end
      TY_BOOL: s1_d.sig = {63'd0, |r[7:0]};
      TY_F32: begin
        s1_d.neg = r[31];
        s1_d.payload = {r[22:0], 29'd0};
        if (e8 == 8'hFF) begin
          s1_d.cls = (r[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
        end else if (e8 == 8'd0) begin
          s1_d.sig = {41'd0, r[22:0]};
          s1_d.exp = -13'sd149;
        end else begin
          s1_d.sig = {40'd0, 1'b1, r[22:0]};
          s1_d.exp = 13'({5'd0, e8}) - 13'sd150;
        end
      end
      TY_F64: begin
        s1_d.neg = r[63];
        s1_d.payload = r[51:0];
        if (e11 == 11'h7FF) begin
          s1_d.cls = (r[51:0] != 52'd0) ? CLS_NAN : CLS_INF;
        end else if (e11 == 11'd0) begin
          s1_d.sig = {12'd0, r[51:0]};
          s1_d.exp = -13'sd1074;
        end else begin
          s1_d.sig = {11'd0, 1'b1, r[51:0]};
          s1_d.exp = 13'({2'd0, e11}) - 13'sd1075;
        end
      end
      default: s1_d.sig = '0;
    endcase
    // finite or zero for anything not already a special
    if (s1_d.cls != CLS_NAN && s1_d.cls != CLS_INF) begin
      s1_d.cls = (s1_d.sig != 64'd0) ? CLS_FIN : CLS_ZERO;
    end
    s1_d.lz = lzc64(s1_d.sig);
  end

  // normalize and align for rounding, and truncate for integer targets
  always_comb begin
    logic [63:0]        norm;
    logic [127:0]       wide;
    logic signed [12:0] bsd;
    logic [12:0]        sh;
    logic [12:0]        nexp;
    logic               dbl;
    dbl = (s1_q.mode == TY_F64);
    norm = s1_q.sig << s1_q.lz;
    bsd = s1_q.exp - $signed({7'd0, s1_q.lz}) + $signed(dbl ? F64_EXP_OFS : F32_EXP_OFS);
    if (bsd >= 13'sd1) begin
      sh = dbl ? F64_SHIFT : F32_SHIFT;
    end else begin
      sh = (dbl ? F64_SHIFT : F32_SHIFT) + 13'd1 - bsd;
    end
    wide = {norm, 64'd0} >> sh[6:0];
    s2_d.cls = s1_q.cls;
    s2_d.neg = s1_q.neg;
    s2_d.payload = s1_q.payload;
    s2_d.mode = s1_q.mode;
    s2_d.biased = bsd;
    s2_d.tiny = (sh > 13'd64);
    s2_d.kept = wide[116:64];
    s2_d.rnd = wide[63];
    s2_d.sticky = |wide[62:0];
    // truncated magnitude, saturated to 64 bits
    nexp = 13'd0 - s1_q.exp;
    case (s1_q.cls)
      CLS_INF: s2_d.mag = '1;
      CLS_FIN: begin
        if (!s1_q.exp[12]) begin
          if (s1_q.exp >= 13'sd64 || s1_q.exp[5:0] > s1_q.lz) s2_d.mag = '1;
          else s2_d.mag = s1_q.sig << s1_q.exp[5:0];
        end else if (s1_q.exp <= -13'sd64) begin
          s2_d.mag = '0;
        end else begin
          s2_d.mag = s1_q.sig >> nexp[5:0];
        end
      end
      default: s2_d.mag = '0;
    endcase
  end

  // round and pack, or saturate into the integer range
  always_comb begin
    logic               dbl;
    logic [5:0]         m;
    logic [63:0]        emax, sbit, inf, mmask, mask, maxp, minmag, fres, ires;
    logic [53:0]        k2;
    logic signed [12:0] bb;
    logic               negv;
    dbl = (s2_q.mode == TY_F64);
    m = dbl ? 6'd52 : 6'd23;
    emax = dbl ? 64'd2047 : 64'd255;
    sbit = s2_q.neg ? (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000) : 64'd0;
    inf = sbit | (emax << m);
    mmask = (64'd1 << m) - 64'd1;
    k2 = {1'b0, s2_q.kept} + {53'd0, s2_q.rnd & (s2_q.sticky | s2_q.kept[0])};
    bb = s2_q.biased;
    case (s2_q.cls)
      CLS_ZERO: fres = sbit;
      CLS_INF:  fres = inf;
      CLS_NAN:  fres = inf | (dbl ? {12'd0, s2_q.payload} : {41'd0, s2_q.payload[51:29]})
                       | (64'd1 << (m - 6'd1));
      default: begin
        if (s2_q.tiny) begin
          fres = sbit;
        end else if (bb < 13'sd1) begin
          fres = sbit | {10'd0, k2};
        end else begin
          if ((k2 >> (m + 6'd1)) != 54'd0) begin
            k2 = k2 >> 1;
            bb = bb + 13'sd1;
          end
          if ({51'd0, bb} >= emax) fres = inf;
          else fres = sbit | ({51'd0, bb} << m) | ({10'd0, k2} & mmask);
        end
      end
    endcase
    // integer saturation
    case (s2_q.mode[1:0])
      2'd0:    mask = 64'h0000_0000_0000_00FF;
      2'd1:    mask = 64'h0000_0000_0000_FFFF;
      2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = '1;
    endcase
    maxp = mask >> 1;
    minmag = maxp + 64'd1;
    negv = s2_q.neg && s2_q.cls != CLS_NAN && s2_q.mag != 64'd0;
    if (!s2_q.mode[2]) begin
      ires = negv ? 64'd0 : ((s2_q.mag > mask) ? mask : s2_q.mag);
    end else if (!negv) begin
      ires = (s2_q.mag > maxp) ? maxp : s2_q.mag;
    end else if (s2_q.mag >= minmag) begin
      ires = (64'd0 - minmag) & mask;
    end else begin
      ires = (64'd0 - s2_q.mag) & mask;
    end
    // destination select
    out_d.error_code = 1'b0;
    if (s2_q.mode <= TY_S64) begin
      out_d.result_value = ires;
    end else if (s2_q.mode == TY_F32 || s2_q.mode == TY_F64) begin
      out_d.result_value = fres;
    end else begin
      out_d.result_value = '0;
      out_d.error_code = 1'b1;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // checks
  `SSC_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without backpressure")
  `SSC_ASSERT(a_err_zero, (out_valid_o && out_data_o.error_code) |-> (out_data_o.result_value == 64'd0), "error result not zero")
  `SSC_ASSERT_NEXT(a_drain, v2_q && !out_stall_i, out_valid_o, "last stage did not advance")

endmodule

### bench/tb_saturating_scalar_type_converter.sv
// testbench for the saturating scalar type converter
// checks every output transfer against an in-bench model of the conversion
// depends on ssc_pkg and saturating_scalar_type_converter
`timescale 1ns / 1ps

// queue of predicted conversions with the result check
class conv_scoreboard;
  ssc_pkg::out_t pending_q[$];
  int unsigned n_checked;
  int unsigned n_errors;

  function new();
    n_checked = 0;
    n_errors = 0;
  endfunction

  function void note_input(ssc_pkg::out_t exp_r);
    pending_q.push_back(exp_r);
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task check_result(ssc_pkg::out_t got);
    ssc_pkg::out_t exp_r;
    n_checked++;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.result_value !== exp_r.result_value)
      report($sformatf("result_value got %h exp %h", got.result_value, exp_r.result_value));
    if (got.error_code !== exp_r.error_code)
      report($sformatf("error_code got %b exp %b", got.error_code, exp_r.error_code));
  endtask
endclass

module tb_saturating_scalar_type_converter;
  import ssc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  conv_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned dst_stall_pct;
  bit hold_off;
  int unsigned quiet_cycles;
  int unsigned n_sent;

  saturating_scalar_type_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // decoded operand: magnitude = sig * 2^scale
  typedef struct {
    cls_e        cls;
    bit          neg;
    bit [63:0]   sig;
    int          scale;
    bit [51:0]   nan_bits;
  } operand_t;

  function automatic operand_t unpack_operand(logic [3:0] st, logic [63:0] raw);
    operand_t o;
    int w;
    bit [63:0] msk, x, b, f;
    bit dbl;
    int m, bias;
    bit [10:0] e, emax;
    o.cls = CLS_ZERO;
    o.neg = 0;
    o.sig = '0;
    o.scale = 0;
    o.nan_bits = '0;
    if (st <= TY_S64) begin
      w = 8 << st[1:0];
      msk = (w == 64) ? '1 : ((64'd1 << w) - 1);
      x = raw & msk;
      if (st >= TY_S8 && x[w-1]) begin
        o.neg = 1;
        x = 64'd0 - (x | ~msk);
      end
      o.sig = x;
    end else if (st == TY_BOOL) begin
      o.sig = (raw[7:0] != 0) ? 64'd1 : 64'd0;
    end else if (st == TY_SCHAR) begin
      x = {56'd0, raw[7:0]};
      if (x[7]) begin
        o.neg = 1;
        x = 64'h100 - x;
      end
      o.sig = x;
    end else if (st == TY_F32 || st == TY_F64) begin
      dbl = (st == TY_F64);
      b = dbl ? raw : {32'd0, raw[31:0]};
      m = dbl ? 52 : 23;
      emax = dbl ? 11'd2047 : 11'd255;
      bias = dbl ? 1023 : 127;
      e = 11'((b >> m) & emax);
      f = b & ((64'd1 << m) - 1);
      o.neg = dbl ? b[63] : b[31];
      if (e == emax) begin
        o.cls = (f != 0) ? CLS_NAN : CLS_INF;
        o.nan_bits = dbl ? f[51:0] : 52'(f << 29);
        return o;
      end
      if (e == 0 && f == 0) return o;
      o.cls = CLS_FIN;
      if (e == 0) begin
        o.sig = f;
        o.scale = 1 - bias - m;
      end else begin
        o.sig = f | (64'd1 << m);
        o.scale = int'(e) - bias - m;
      end
      return o;
    end
    o.cls = (o.sig != 0) ? CLS_FIN : CLS_ZERO;
    return o;
  endfunction

  // round to nearest even into binary32 or binary64
  function automatic bit [63:0] round_to_float(bit neg, bit [63:0] sig, int scale, bit dbl);
    int m, bias, biased, s, extra;
    bit [63:0] emax, sbit, kept, rem, half;
    m = dbl ? 52 : 23;
    bias = dbl ? 1023 : 127;
    emax = dbl ? 64'd2047 : 64'd255;
    sbit = neg ? (64'd1 << (dbl ? 63 : 31)) : 64'd0;
    while (!sig[63]) begin
      sig = sig << 1;
      scale--;
    end
    biased = scale + 63 + bias;
    if (biased >= 1) begin
      s = 63 - m;
    end else begin
      extra = 1 - biased;
      if (extra > 64) return sbit;
      s = 63 - m + extra;
      if (s > 64) return sbit;
    end
    if (s == 64) begin
      kept = 0;
      rem = sig;
      half = 64'd1 << 63;
    end else begin
      kept = sig >> s;
      rem = sig & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
    end
    if (rem > half || (rem == half && kept[0])) kept++;
    if (biased < 1) return sbit | kept;
    if ((kept >> (m + 1)) != 0) begin
      kept = kept >> 1;
      biased++;
    end
    if (biased >= int'(emax)) return sbit | (emax << m);
    return sbit | (64'(biased) << m) | (kept & ((64'd1 << m) - 1));
  endfunction

  function automatic bit [63:0] convert_float(operand_t o, bit dbl);
    int m;
    bit [63:0] emax, sbit, p;
    m = dbl ? 52 : 23;
    emax = dbl ? 64'd2047 : 64'd255;
    sbit = o.neg ? (64'd1 << (dbl ? 63 : 31)) : 64'd0;
    case (o.cls)
      CLS_ZERO: return sbit;
      CLS_INF:  return sbit | (emax << m);
      CLS_NAN: begin
        p = dbl ? {12'd0, o.nan_bits} : {12'd0, o.nan_bits} >> 29;
        return sbit | (emax << m) | p | (64'd1 << (m - 1));
      end
      default:  return round_to_float(o.neg, o.sig, o.scale, dbl);
    endcase
  endfunction

  // truncate toward zero, saturate the magnitude, then clamp to the target
  function automatic bit [63:0] convert_int(operand_t o, logic [3:0] t);
    int w;
    bit [63:0] msk, mag, minmag, maxp;
    bit neg;
    w = 8 << t[1:0];
    msk = (w == 64) ? '1 : ((64'd1 << w) - 1);
    if (o.cls == CLS_ZERO || o.cls == CLS_NAN) mag = 0;
    else if (o.cls == CLS_INF) mag = '1;
    else if (o.scale >= 0) begin
      if (o.scale >= 64 || o.sig > ({64{1'b1}} >> o.scale)) mag = '1;
      else mag = o.sig << o.scale;
    end else if (o.scale <= -64) mag = 0;
    else mag = o.sig >> (-o.scale);
    neg = o.neg && o.cls != CLS_NAN && mag != 0;
    if (t <= TY_U64) begin
      if (neg) return 0;
      return (mag > msk) ? msk : mag;
    end
    minmag = 64'd1 << (w - 1);
    maxp = minmag - 1;
    if (!neg) return (mag > maxp) ? maxp : mag;
    if (mag >= minmag) return (64'd0 - minmag) & msk;
    return (64'd0 - mag) & msk;
  endfunction

  function automatic out_t predict_conversion(in_t it);
    out_t r;
    operand_t o;
    o = unpack_operand(it.source_type, it.raw_value);
    r.result_value = '0;
    r.error_code = 1'b0;
    if (it.mode <= TY_S64) r.result_value = convert_int(o, it.mode);
    else if (it.mode == TY_F32) r.result_value = convert_float(o, 1'b0);
    else if (it.mode == TY_F64) r.result_value = convert_float(o, 1'b1);
    else r.error_code = 1'b1;
    return r;
  endfunction

  // interesting raw words: extremes, signs, float specials
  function automatic logic [63:0] pick_raw();
    case ($urandom_range(0, 15))
      0: return 64'd0;
      1: return '1;
      2: return 64'h7FFF_FFFF_FFFF_FFFF;
      3: return 64'h8000_0000_0000_0000;
      4: return {32'd0, 1'b0, 8'hFF, 23'(($urandom_range(0, 1)) ? $urandom : 0)};
      5: return {1'b0, 11'h7FF, 52'({$urandom, $urandom} & (($urandom_range(0, 1)) ? '1 : 0))};
      6: return {$urandom, 1'b1, 8'(127 + $urandom_range(0, 70)), 23'($urandom)};
      7: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'(1023 + $urandom_range(0, 70)),
                 52'({$urandom, $urandom})};
      8: return {$urandom, $urandom} >> $urandom_range(0, 63);
      9: return {$urandom, 9'd0, 23'($urandom)};
      10: return {12'h800, 52'({$urandom, $urandom})};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(in_t it);
    while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(predict_conversion(it));
    n_sent++;
  endtask

  // drop valid for one cycle after a burst
  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    in_t it;
    repeat (count) begin
      it.source_type = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
      it.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
      it.raw_value = pick_raw();
      send_item(it);
    end
    end_burst();
  endtask

  task automatic send_directed();
    in_t it;
    logic [63:0] raws[12];
    raws = '{64'd0, '1, 64'h80, 64'h7F, 64'h7F80_0000, 64'hFF80_0000,
             64'h7FA0_0001, 64'hFFF8_0000_0000_0001, 64'h8000_0000,
             64'h0000_0001, 64'h3F00_0000, 64'h43E0_0000_0000_0000};
    for (int i = 0; i < 25; i++) begin
      it.source_type = 4'(i % 16);
      it.mode = 4'((i * 7) % 16);
      it.raw_value = raws[i % 12];
      send_item(it);
    end
    end_burst();
  endtask

  // receiver stall pattern, with one long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_off || (dst_stall_pct != 0 && $urandom_range(1, 100) <= dst_stall_pct);
    end
  end

  // output transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_off)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    n_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    wait_drained();

    // long receiver hold-off so the pipeline fills and stalls its input
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(40);
    join
    wait_drained();

    send_random(300);
    src_idle_pct = 84;
    send_random(300);
    src_idle_pct = 0;
    dst_stall_pct = 84;
    send_random(300);
    src_idle_pct = 13;
    dst_stall_pct = 13;
    send_random(300);
    wait_drained();

    $display("%0d conversions sent, %0d results checked across idle and stall phases",
             n_sent, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
